[rtl/core/zepc_pkg.sv]
// zepc_pkg: shared types, constants and helpers for the zebra exposure classifier
// no dependencies
`timescale 1ns / 1ps

package zepc_pkg;

   localparam int WORD_W  = 24;
   localparam int POS_W   = 12;
   localparam int FRM_W   = 4;
   localparam int CHAN_W  = 8;
   localparam int MARK_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int MODE_W  = 3;

   // signed width of one channel sum in 12-bit fixed point
   localparam int SUM_W   = 23;
   localparam int FRAC_W  = 12;

   localparam logic signed [SUM_W-1:0] K_RV = 23'sd5743;
   localparam logic signed [SUM_W-1:0] K_GU = 23'sd1411;
   localparam logic signed [SUM_W-1:0] K_GV = 23'sd2925;
   localparam logic signed [SUM_W-1:0] K_BU = 23'sd7258;
   localparam logic [CHAN_W:0]         CHROMA_BIAS = 9'd128;
   localparam logic [FRAC_W-1:0]       ROUND_HALF  = 12'h800;
   localparam logic [CHAN_W-1:0]       CHAN_MAX    = 8'd255;

   localparam logic [MARK_W-1:0] MARK_NONE  = 4'd0;
   localparam logic [MARK_W-1:0] MARK_RED   = 4'd4;
   localparam logic [MARK_W-1:0] MARK_GREEN = 4'd2;
   localparam logic [MARK_W-1:0] MARK_BLUE  = 4'd1;
   localparam logic [MARK_W-1:0] MARK_OVER  = 4'd8;
   localparam logic [MARK_W-1:0] MARK_UNDER = 4'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_OVER_SETTING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTICHANNEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZEBRA_MODE   = 2'd3;

   localparam logic [CHAN_W-1:0] OVER_SETTING_RST = 8'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_STRIPE4 = 3'd0,
      MODE_STRIPE8 = 3'd1,
      MODE_SOLID   = 3'd2,
      MODE_BLINK1  = 3'd3,
      MODE_BLINK2  = 3'd4,
      MODE_BLINK3  = 3'd5
   } zebra_mode_type;

   // control that travels alongside the channel sums
   typedef struct packed {
      logic              valid;
      logic              show;
      logic [CHAN_W-1:0] luma;
   } pix_ctrl_type;

   // clamp a channel sum to 0..255 and test it against the threshold
   function automatic logic chan_over(input logic signed [SUM_W-1:0] sum,
                                      input logic [CHAN_W-1:0] thr);
      logic [SUM_W-FRAC_W-1:0] whole;
      logic [CHAN_W-1:0]       chan;
      whole = sum[SUM_W-1:FRAC_W];
      if (sum[SUM_W-1]) begin
         chan = '0;
      end else if (whole > {{(SUM_W-FRAC_W-CHAN_W){1'b0}}, CHAN_MAX}) begin
         chan = CHAN_MAX;
      end else begin
         chan = whole[CHAN_W-1:0];
      end
      return chan > thr;
   endfunction

endpackage

[rtl/core/zepc_rgb_conv.sv]
// zepc_rgb_conv: registered fixed-point yuv to rgb channel sums
// depends on zepc_pkg
`timescale 1ns / 1ps

module zepc_rgb_conv (
   input  logic                              clock,
   input  logic [zepc_pkg::WORD_W-1:0]       pixel_word,
   output logic signed [zepc_pkg::SUM_W-1:0] sum_r_ff,
   output logic signed [zepc_pkg::SUM_W-1:0] sum_g_ff,
   output logic signed [zepc_pkg::SUM_W-1:0] sum_b_ff
);
   import zepc_pkg::*;

   logic [CHAN_W-1:0]        v_raw, y_raw, u_raw;
   logic signed [CHAN_W:0]   vv, uu;
   logic signed [SUM_W-1:0]  vv_ext, uu_ext, ys;
   logic signed [SUM_W-1:0]  sum_r_in, sum_g_in, sum_b_in;

   assign v_raw = pixel_word[7:0];
   assign y_raw = pixel_word[15:8];
   assign u_raw = pixel_word[23:16];

   // chroma offset removed, kept as 9-bit signed
   assign vv = $signed({1'b0, v_raw} - CHROMA_BIAS);
   assign uu = $signed({1'b0, u_raw} - CHROMA_BIAS);
   assign vv_ext = {{(SUM_W-CHAN_W-1){vv[CHAN_W]}}, vv};
   assign uu_ext = {{(SUM_W-CHAN_W-1){uu[CHAN_W]}}, uu};

   // luma scaled with rounding half already added
   assign ys = $signed({{(SUM_W-CHAN_W-FRAC_W){1'b0}}, y_raw, ROUND_HALF});

   assign sum_r_in = ys + vv_ext * K_RV;
   assign sum_g_in = ys - uu_ext * K_GU - vv_ext * K_GV;
   assign sum_b_in = ys + uu_ext * K_BU;

   always_ff @(posedge clock) begin
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
   end

endmodule

[rtl/core/zepc_classify.sv]
// zepc_classify: threshold tests and the registered result
// depends on zepc_pkg
`timescale 1ns / 1ps

module zepc_classify (
   input  logic                              clock,
   input  logic                              reset,
   input  zepc_pkg::pix_ctrl_type            ctrl,
   input  logic signed [zepc_pkg::SUM_W-1:0] sum_r,
   input  logic signed [zepc_pkg::SUM_W-1:0] sum_g,
   input  logic signed [zepc_pkg::SUM_W-1:0] sum_b,
   input  logic [zepc_pkg::CHAN_W-1:0]       over_setting,
   input  logic [zepc_pkg::CHAN_W-1:0]       under_level,
   input  logic                              multichannel,
   output logic                              rsp_valid_ff,
   output logic [zepc_pkg::MARK_W-1:0]       rsp_mark_ff,
   output logic                              rsp_marked_ff
);
   import zepc_pkg::*;

   logic [CHAN_W-1:0] thr;
   logic [MARK_W-1:0] mark_in;

   assign thr = CHAN_MAX - over_setting;

   always_comb begin
      mark_in = MARK_NONE;
      if (ctrl.show) begin
         if (multichannel) begin
            if (chan_over(sum_r, thr)) mark_in = mark_in | MARK_RED;
            if (chan_over(sum_g, thr)) mark_in = mark_in | MARK_GREEN;
            if (chan_over(sum_b, thr)) mark_in = mark_in | MARK_BLUE;
         end else if (ctrl.luma > thr) begin
            mark_in = MARK_OVER;
         end else if (ctrl.luma < under_level) begin
            mark_in = MARK_UNDER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.valid;
      end
      rsp_mark_ff   <= mark_in;
      rsp_marked_ff <= (mark_in != MARK_NONE);
   end

endmodule

[rtl/core/zebra_exposure_pixel_classifier_unit.sv]
// zebra_exposure_pixel_classifier_unit: top level of the zebra exposure classifier
// depends on zepc_pkg, zepc_rgb_conv, zepc_classify
`timescale 1ns / 1ps

// usage
// - a pixel pair transfer happens on a rising edge with start high and busy low;
//   busy is only high while reset is held, so one pair can enter every cycle
// - the pair passes an input register, a channel sum register and the result
//   register in that order; rsp_valid comes from the result register, high for one cycle
// - throughput is one pair per clock while busy is low, set by the three-stage
//   pipeline with no feedback between pairs
// - rsp_mark and rsp_marked are valid only while rsp_valid is high; the receiver
//   cannot stall, every result must be taken in the cycle it is shown
// - csr writes take effect at the edge where csr_wr_en is high; index 0 over
//   setting, 1 under level, 2 multichannel, 3 zebra mode; write only while no
//   pair is in flight
// - synchronous reset clears the pipeline valid bits and loads the register
//   defaults (over setting 1, everything else 0)
module zebra_exposure_pixel_classifier_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [zepc_pkg::WORD_W-1:0]         req_pixel_word,
   input  logic [zepc_pkg::POS_W-1:0]          req_column,
   input  logic [zepc_pkg::POS_W-1:0]          req_row,
   input  logic [zepc_pkg::FRM_W-1:0]          req_frame_count,
   input  logic                                csr_wr_en,
   input  logic [zepc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [zepc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_valid,
   output logic [zepc_pkg::MARK_W-1:0]         rsp_mark,
   output logic                                rsp_marked
);
   import zepc_pkg::*;

   // configuration registers
   logic [CHAN_W-1:0] over_setting_ff;
   logic [CHAN_W-1:0] under_level_ff;
   logic              multichannel_ff;
   logic [MODE_W-1:0] zebra_mode_ff;

   // input stage
   logic              accept;
   logic              in_valid_ff;
   logic [WORD_W-1:0] word_ff;
   logic [POS_W-1:0]  column_ff;
   logic [POS_W-1:0]  row_ff;
   logic [FRM_W-1:0]  frame_ff;

   // phase gating
   logic [FRM_W-1:0]  phase;
   logic [FRM_W-1:0]  diag;
   logic              stripe;
   logic              show;

   pix_ctrl_type      ctrl_in, ctrl_ff;

   logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         over_setting_ff <= OVER_SETTING_RST;
         under_level_ff  <= '0;
         multichannel_ff <= 1'b0;
         zebra_mode_ff   <= MODE_STRIPE4;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OVER_SETTING: over_setting_ff <= csr_wdata;
            CSR_UNDER_LEVEL:  under_level_ff  <= csr_wdata;
            CSR_MULTICHANNEL: multichannel_ff <= csr_wdata[0];
            CSR_ZEBRA_MODE:   zebra_mode_ff   <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // input register, payload held without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      word_ff   <= req_pixel_word;
      column_ff <= req_column;
      row_ff    <= req_row;
      frame_ff  <= req_frame_count;
   end

   // phase selection; unused modes fall back to the two-frame blink
   always_comb begin
      unique case (zebra_mode_ff)
         MODE_STRIPE4: phase = 4'd4;
         MODE_STRIPE8: phase = 4'd8;
         MODE_SOLID:   phase = 4'd1;
         MODE_BLINK1:  phase = {3'b000, frame_ff[0]};
         MODE_BLINK3:  phase = {1'b0, frame_ff[2], 2'b00};
         default:      phase = {2'b00, frame_ff[1], 1'b0};
      endcase
   end

   // diagonal index only needs its low bits
   assign diag   = row_ff[FRM_W-1:0] - column_ff[FRM_W-1:0] - frame_ff;
   assign stripe = (zebra_mode_ff == MODE_STRIPE4) || (zebra_mode_ff == MODE_STRIPE8);
   assign show   = (phase != '0) && !(stripe && ((diag & phase) != '0));

   assign ctrl_in.valid = in_valid_ff;
   assign ctrl_in.show  = show;
   assign ctrl_in.luma  = word_ff[15:8];

   // control rides beside the channel sum register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.show <= ctrl_in.show;
      ctrl_ff.luma <= ctrl_in.luma;
   end

   zepc_rgb_conv u_rgb_conv (
      .clock      (clock),
      .pixel_word (word_ff),
      .sum_r_ff   (sum_r),
      .sum_g_ff   (sum_g),
      .sum_b_ff   (sum_b)
   );

   zepc_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl_ff),
      .sum_r         (sum_r),
      .sum_g         (sum_g),
      .sum_b         (sum_b),
      .over_setting  (over_setting_ff),
      .under_level   (under_level_ff),
      .multichannel  (multichannel_ff),
      .rsp_valid_ff  (rsp_valid),
      .rsp_mark_ff   (rsp_mark),
      .rsp_marked_ff (rsp_marked)
   );

endmodule
